// File: rtl/ldpc_pkg.sv
// ----------------------------------------------------------------------------
// ldpc_pkg
// Constants, types and arithmetic helpers of the layered min-sum decoder.
// ----------------------------------------------------------------------------
package ldpc_pkg;

	localparam int CHECK_ROWS   = 648;
	localparam int CODE_COLUMNS = 1296;
	localparam int MAX_DEGREE   = 8;
	localparam int LLR_W        = 10;

	localparam int EDGES   = CHECK_ROWS * MAX_DEGREE;
	localparam int ROW_W   = $clog2(CHECK_ROWS);
	localparam int SLOT_W  = $clog2(MAX_DEGREE);
	localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
	localparam int COL_W   = $clog2(CODE_COLUMNS);
	localparam int EDGE_AW = $clog2(EDGES);
	localparam int MAG_W   = LLR_W - 1;
	localparam int OFF_W   = 6;
	localparam int ITER_W  = 5;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	typedef logic signed [LLR_W-1:0] llr_t;
	typedef logic [MAG_W-1:0] mag_t;

	typedef enum logic [1:0] {
		CMD_TABLE = 2'd0,
		CMD_LLR   = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_OFFSET     = 1'b0,
		CFG_ITERATIONS = 1'b1
	} cfg_idx_t;

	function automatic llr_t sat_llr(input logic signed [LLR_W:0] v);
		logic signed [LLR_W:0] hi;
		logic signed [LLR_W:0] lo;
		hi = (LLR_W+1)'(MAG_MAX);
		lo = -hi - (LLR_W+1)'(1);
		if (v > hi) begin
			return llr_t'(hi);
		end else if (v < lo) begin
			return llr_t'(lo);
		end
		return llr_t'(v);
	endfunction

	function automatic mag_t mag_llr(input llr_t v);
		logic signed [LLR_W:0] a;
		a = (v < 0) ? -(LLR_W+1)'(v) : (LLR_W+1)'(v);
		if (a > (LLR_W+1)'(MAG_MAX)) begin
			return MAG_MAX;
		end
		return mag_t'(a);
	endfunction

endpackage

// File: rtl/ldpc_layered_offset_min_sum_decoder.sv
// ----------------------------------------------------------------------------
// ldpc_layered_offset_min_sum_decoder
// Layered offset min-sum LDPC decoder built around four on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the in channel (in_valid, in_stall) and carry one of four
// commands. Table and LLR writes give no result.
// A read gives one result item (kind 0) through states S_RD and S_PUT, and
// the input stalls until that result is loaded into the output register.
// A run item decodes the loaded word and gives one result item (kind 1).
// Results leave on the out channel (out_valid, out_stall) from an output
// register; the block returns to accepting items while a result waits, and
// it holds a new result until the register is free.
// A decode repeats, for each configured iteration and each row, the degree
// read (S_DEG, S_DEGW), then per edge the gathering of the extrinsic value
// through the chained table, posterior and message reads (S_COL, S_LLR,
// S_EXT), then per edge the update (S_UPD); S_PUT then loads the result.
// Rows of degree zero go through the degree read only.
// Configuration writes (cfg_valid, cfg_ready) are always taken.
// After reset the row degree memory is cleared, one row per cycle, for all
// 648 rows; no item is accepted in that time.
// ----------------------------------------------------------------------------
module ldpc_layered_offset_min_sum_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic [9:0]                      check_row,
	input  logic [2:0]                      slot,
	input  logic [10:0]                     column,
	input  logic [3:0]                      row_degree,
	input  logic signed [9:0]               llr_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            kind,
	output logic signed [9:0]               llr_out,
	output logic [10:0]                     read_column,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [5:0]                      cfg_data
);

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_DEG  = 10'b0000000100,
		S_DEGW = 10'b0000001000,
		S_COL  = 10'b0000010000,
		S_LLR  = 10'b0000100000,
		S_EXT  = 10'b0001000000,
		S_UPD  = 10'b0010000000,
		S_RD   = 10'b0100000000,
		S_PUT  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [ldpc_pkg::COL_W-1:0]   edge_col_mem [ldpc_pkg::EDGES];
	logic [ldpc_pkg::DEG_W-1:0]   deg_mem      [ldpc_pkg::CHECK_ROWS];
	ldpc_pkg::llr_t               post_mem     [ldpc_pkg::CODE_COLUMNS];
	ldpc_pkg::llr_t               msg_mem      [ldpc_pkg::EDGES];

	logic [ldpc_pkg::COL_W-1:0]   edge_col_rd;
	logic [ldpc_pkg::DEG_W-1:0]   deg_rd;
	ldpc_pkg::llr_t               post_rd;
	ldpc_pkg::llr_t               msg_rd;

	logic [ldpc_pkg::OFF_W-1:0]   offset_q;
	logic [ldpc_pkg::ITER_W-1:0]  iterations_q;

	logic [ldpc_pkg::ROW_W-1:0]   row_q;
	logic [ldpc_pkg::ITER_W-1:0]  iter_q;
	logic [ldpc_pkg::DEG_W-1:0]   deg_q;
	logic [ldpc_pkg::DEG_W-1:0]   edge_q;
	ldpc_pkg::llr_t               ext_q [ldpc_pkg::MAX_DEGREE];
	logic [ldpc_pkg::COL_W-1:0]   col_q [ldpc_pkg::MAX_DEGREE];
	ldpc_pkg::mag_t               min1_q;
	ldpc_pkg::mag_t               min2_q;
	logic [ldpc_pkg::SLOT_W-1:0]  idx_q;
	logic                         par_q;
	logic [1:0]                   zc_q;

	logic                         res_kind_q;
	ldpc_pkg::llr_t               res_llr_q;
	logic [ldpc_pkg::COL_W-1:0]   res_col_q;
	logic                         rd_ok_q;

	logic                         out_vld_q;
	logic                         kind_q;
	ldpc_pkg::llr_t               llr_out_q;
	logic [ldpc_pkg::COL_W-1:0]   read_column_q;

	logic                         in_acc;
	logic [ldpc_pkg::SLOT_W-1:0]  e_idx;
	logic [ldpc_pkg::EDGE_AW-1:0] row_base;
	logic [ldpc_pkg::EDGE_AW-1:0] edge_addr;
	logic [ldpc_pkg::COL_W-1:0]   col_clamp;
	ldpc_pkg::llr_t               ext_now;
	ldpc_pkg::mag_t               mag_now;
	ldpc_pkg::llr_t               ext_i;
	ldpc_pkg::mag_t               min_other;
	ldpc_pkg::mag_t               mag_new;
	ldpc_pkg::llr_t               msg_new;
	logic                         neg_other;
	logic                         zero_other;
	logic                         last_edge;
	logic                         last_row;
	logic                         last_iter;

	logic                         deg_we;
	logic [ldpc_pkg::ROW_W-1:0]   deg_wa;
	logic [ldpc_pkg::DEG_W-1:0]   deg_wd;
	logic                         post_we;
	logic [ldpc_pkg::COL_W-1:0]   post_wa;
	ldpc_pkg::llr_t               post_wd;
	logic [ldpc_pkg::COL_W-1:0]   post_ra;
	logic                         tbl_ok;
	logic [ldpc_pkg::COL_W-1:0]   in_col_clamp;
	logic [ldpc_pkg::DEG_W-1:0]   in_deg_clamp;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid   = out_vld_q;
	assign kind        = kind_q;
	assign llr_out     = llr_out_q;
	assign read_column = read_column_q;

	assign e_idx     = edge_q[ldpc_pkg::SLOT_W-1:0];
	assign row_base  = ldpc_pkg::EDGE_AW'(row_q) * ldpc_pkg::EDGE_AW'(ldpc_pkg::MAX_DEGREE);
	assign edge_addr = row_base + ldpc_pkg::EDGE_AW'(e_idx);
	assign col_clamp = (edge_col_rd >= ldpc_pkg::COL_W'(ldpc_pkg::CODE_COLUMNS))
		? ldpc_pkg::COL_W'(ldpc_pkg::CODE_COLUMNS - 1) : edge_col_rd;

	assign ext_now = ldpc_pkg::sat_llr((ldpc_pkg::LLR_W+1)'(post_rd)
		- ((iter_q == '0) ? '0 : (ldpc_pkg::LLR_W+1)'(msg_rd)));
	assign mag_now = ldpc_pkg::mag_llr(ext_now);

	assign ext_i      = ext_q[e_idx];
	assign min_other  = (idx_q == e_idx) ? min2_q : min1_q;
	assign mag_new    = (min_other > ldpc_pkg::MAG_W'(offset_q))
		? min_other - ldpc_pkg::MAG_W'(offset_q) : '0;
	assign neg_other  = par_q ^ ext_i[ldpc_pkg::LLR_W-1];
	assign zero_other = (zc_q - {1'b0, (ext_i == '0)}) != 2'd0;
	assign msg_new    = zero_other ? '0
		: (neg_other ? -ldpc_pkg::llr_t'(mag_new) : ldpc_pkg::llr_t'(mag_new));

	assign last_edge = (edge_q == deg_q - ldpc_pkg::DEG_W'(1));
	assign last_row  = (row_q == ldpc_pkg::ROW_W'(ldpc_pkg::CHECK_ROWS - 1));
	assign last_iter = (iter_q == iterations_q - ldpc_pkg::ITER_W'(1));

	assign tbl_ok = (check_row < ldpc_pkg::ROW_W'(ldpc_pkg::CHECK_ROWS))
		&& (32'(slot) < ldpc_pkg::MAX_DEGREE);
	assign in_col_clamp = (column >= ldpc_pkg::COL_W'(ldpc_pkg::CODE_COLUMNS))
		? ldpc_pkg::COL_W'(ldpc_pkg::CODE_COLUMNS - 1) : column;
	assign in_deg_clamp = (row_degree > ldpc_pkg::DEG_W'(ldpc_pkg::MAX_DEGREE))
		? ldpc_pkg::DEG_W'(ldpc_pkg::MAX_DEGREE) : row_degree;

	always_comb begin
		deg_we  = 1'b0;
		deg_wa  = check_row;
		deg_wd  = in_deg_clamp;
		post_we = 1'b0;
		post_wa = column;
		post_wd = llr_in;
		post_ra = column;
		if (state_q == S_CLR) begin
			deg_we = 1'b1;
			deg_wa = row_q;
			deg_wd = '0;
		end else if (in_acc && cmd == ldpc_pkg::CMD_TABLE && tbl_ok) begin
			deg_we = 1'b1;
		end
		if (state_q == S_UPD) begin
			post_we = 1'b1;
			post_wa = col_q[e_idx];
			post_wd = ldpc_pkg::sat_llr((ldpc_pkg::LLR_W+1)'(ext_i)
				+ (ldpc_pkg::LLR_W+1)'(msg_new));
		end else if (in_acc && cmd == ldpc_pkg::CMD_LLR
				&& column < ldpc_pkg::COL_W'(ldpc_pkg::CODE_COLUMNS)) begin
			post_we = 1'b1;
		end
		if (state_q == S_LLR) begin
			post_ra = col_clamp;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == ldpc_pkg::CMD_TABLE && tbl_ok) begin
			edge_col_mem[ldpc_pkg::EDGE_AW'(check_row) * ldpc_pkg::EDGE_AW'(ldpc_pkg::MAX_DEGREE)
				+ ldpc_pkg::EDGE_AW'(slot)] <= in_col_clamp;
		end
		edge_col_rd <= edge_col_mem[edge_addr];
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		deg_rd <= deg_mem[row_q];
	end

	always_ff @(posedge clk) begin
		if (post_we) begin
			post_mem[post_wa] <= post_wd;
		end
		post_rd <= post_mem[post_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			msg_mem[edge_addr] <= msg_new;
		end
		msg_rd <= msg_mem[edge_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= ldpc_pkg::OFF_W'(5);
			iterations_q <= ldpc_pkg::ITER_W'(5);
		end else if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0) begin
			unique case (ldpc_pkg::cfg_idx_t'(cfg_index[0]))
				ldpc_pkg::CFG_OFFSET:     offset_q     <= cfg_data;
				ldpc_pkg::CFG_ITERATIONS: iterations_q <= cfg_data[ldpc_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LLR) begin
			col_q[e_idx] <= col_clamp;
		end
		if (state_q == S_EXT) begin
			ext_q[e_idx] <= ext_now;
		end
		if (state_q == S_RD) begin
			res_llr_q <= rd_ok_q ? post_rd : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			row_q         <= '0;
			iter_q        <= '0;
			deg_q         <= '0;
			edge_q        <= '0;
			min1_q        <= ldpc_pkg::MAG_MAX;
			min2_q        <= ldpc_pkg::MAG_MAX;
			idx_q         <= '0;
			par_q         <= 1'b0;
			zc_q          <= '0;
			res_kind_q    <= 1'b0;
			res_col_q     <= '0;
			rd_ok_q       <= 1'b0;
			out_vld_q     <= 1'b0;
			kind_q        <= 1'b0;
			llr_out_q     <= '0;
			read_column_q <= '0;
		end else begin
			if (out_vld_q && !out_stall && state_q != S_PUT) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (last_row) begin
						row_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						row_q <= row_q + ldpc_pkg::ROW_W'(1);
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						unique case (ldpc_pkg::cmd_t'(cmd))
							ldpc_pkg::CMD_RUN: begin
								res_kind_q <= 1'b1;
								res_col_q  <= '0;
								row_q      <= '0;
								iter_q     <= '0;
								state_q    <= (iterations_q == '0) ? S_PUT : S_DEG;
							end
							ldpc_pkg::CMD_READ: begin
								res_kind_q <= 1'b0;
								res_col_q  <= column;
								rd_ok_q    <= column < ldpc_pkg::COL_W'(ldpc_pkg::CODE_COLUMNS);
								state_q    <= S_RD;
							end
							default: ;
						endcase
					end
				end
				S_DEG: begin
					state_q <= S_DEGW;
				end
				S_DEGW: begin
					deg_q  <= deg_rd;
					edge_q <= '0;
					min1_q <= ldpc_pkg::MAG_MAX;
					min2_q <= ldpc_pkg::MAG_MAX;
					idx_q  <= '0;
					par_q  <= 1'b0;
					zc_q   <= '0;
					if (deg_rd == '0) begin
						if (last_row) begin
							row_q <= '0;
							if (last_iter) begin
								state_q <= S_PUT;
							end else begin
								state_q <= S_DEG;
								iter_q  <= iter_q + ldpc_pkg::ITER_W'(1);
							end
						end else begin
							state_q <= S_DEG;
							row_q   <= row_q + ldpc_pkg::ROW_W'(1);
						end
					end else begin
						state_q <= S_COL;
					end
				end
				S_COL: begin
					state_q <= S_LLR;
				end
				S_LLR: begin
					state_q <= S_EXT;
				end
				S_EXT: begin
					if (mag_now < min1_q) begin
						min2_q <= min1_q;
						min1_q <= mag_now;
						idx_q  <= e_idx;
					end else if (mag_now < min2_q) begin
						min2_q <= mag_now;
					end
					par_q <= par_q ^ ext_now[ldpc_pkg::LLR_W-1];
					if (ext_now == '0 && zc_q != 2'd2) begin
						zc_q <= zc_q + 2'd1;
					end
					if (last_edge) begin
						edge_q  <= '0;
						state_q <= S_UPD;
					end else begin
						edge_q  <= edge_q + ldpc_pkg::DEG_W'(1);
						state_q <= S_COL;
					end
				end
				S_UPD: begin
					if (last_edge) begin
						if (last_row) begin
							row_q <= '0;
							if (last_iter) begin
								state_q <= S_PUT;
							end else begin
								state_q <= S_DEG;
								iter_q  <= iter_q + ldpc_pkg::ITER_W'(1);
							end
						end else begin
							state_q <= S_DEG;
							row_q   <= row_q + ldpc_pkg::ROW_W'(1);
						end
					end else begin
						edge_q <= edge_q + ldpc_pkg::DEG_W'(1);
					end
				end
				S_RD: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (!out_vld_q || !out_stall) begin
						out_vld_q     <= 1'b1;
						kind_q        <= res_kind_q;
						llr_out_q     <= res_kind_q ? '0 : res_llr_q;
						read_column_q <= res_col_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_min_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (min1_q <= min2_q))
		else $error("min-sum minima out of order");

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD || state_q == S_EXT) |-> (edge_q < deg_q || state_q == S_EXT))
		else $error("edge counter beyond row degree");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_PUT))
		else $error("result raised outside result state");

	a_upd_deg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (deg_q != '0))
		else $error("update of an empty row");

endmodule

// File: sim/ldpc_layered_offset_min_sum_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpc_layered_offset_min_sum_decoder_tb
// Self-checking testbench of the layered offset min-sum LDPC decoder.
// It builds small parity-check tables, loads channel LLRs, runs decodes and
// reads posteriors back under random idling on both channels. A predictor
// of the decoder produces each expected result when its item is accepted,
// and a monitor compares every result with the oldest expectation.
// ----------------------------------------------------------------------------
module ldpc_layered_offset_min_sum_decoder_tb;

	typedef struct {
		ldpc_pkg::cmd_t op;
		logic [9:0]     row;
		logic [2:0]     slt;
		logic [10:0]    col;
		logic [3:0]     deg;
		logic [9:0]     llr;
	} dec_item_t;

	typedef struct {
		logic              knd;
		logic signed [9:0] llr;
		logic [10:0]       col;
	} dec_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd = '0;
	logic [9:0]        check_row = '0;
	logic [2:0]        slot = '0;
	logic [10:0]       column = '0;
	logic [3:0]        row_degree = '0;
	logic signed [9:0] llr_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              kind;
	logic signed [9:0] llr_out;
	logic [10:0]       read_column;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [5:0]        cfg_data = '0;

	dec_item_t   pending_items[$];
	dec_result_t expected_results[$];
	dec_item_t   offered;
	bit          taken;
	int          errors;
	int          in_idle_pct = 34;
	int          out_idle_pct = 34;
	int          hold_req;
	int          hold_seen;
	int          hold_left;

	// Predicted decoder state.
	int          edge_col[ldpc_pkg::EDGES];
	int          deg_tab[ldpc_pkg::CHECK_ROWS];
	int          post[ldpc_pkg::CODE_COLUMNS];
	int          msg[ldpc_pkg::EDGES];
	int          pred_offset = 5;
	int          pred_iters = 5;

	// What the stimulus has written so far, so no unwritten entry is used.
	bit          slot_written[ldpc_pkg::CHECK_ROWS][ldpc_pkg::MAX_DEGREE];
	bit          col_written[ldpc_pkg::CODE_COLUMNS];
	int          written_cols[$];

	ldpc_layered_offset_min_sum_decoder u_top (.*);

	always #5 clk = ~clk;

	function automatic int clip_llr(int v);
		if (v > 511) return 511;
		if (v < -512) return -512;
		return v;
	endfunction

	function automatic void decode_word();
		int ext[ldpc_pkg::MAX_DEGREE];
		int d, b, prod, mn, m, a, s;
		for (int e = 0; e < ldpc_pkg::EDGES; e++) msg[e] = 0;
		for (int it = 0; it < pred_iters; it++) begin
			for (int r = 0; r < ldpc_pkg::CHECK_ROWS; r++) begin
				d = deg_tab[r];
				b = r * ldpc_pkg::MAX_DEGREE;
				for (int i = 0; i < d; i++)
					ext[i] = clip_llr(post[edge_col[b+i]] - msg[b+i]);
				for (int i = 0; i < d; i++) begin
					prod = 1;
					mn = 511;
					for (int k = 0; k < d; k++) begin
						if (k != i) begin
							s = (ext[k] > 0) - (ext[k] < 0);
							prod = prod * s;
							a = ext[k] < 0 ? -ext[k] : ext[k];
							if (a > 511) a = 511;
							if (a < mn) mn = a;
						end
					end
					m = mn - pred_offset;
					if (m < 0) m = 0;
					msg[b+i] = prod * m;
					post[edge_col[b+i]] = clip_llr(ext[i] + msg[b+i]);
				end
			end
		end
	endfunction

	function automatic void predict_item(dec_item_t it);
		dec_result_t res;
		int c;
		c = it.col;
		case (it.op)
			ldpc_pkg::CMD_TABLE: begin
				if (it.row < ldpc_pkg::CHECK_ROWS) begin
					edge_col[it.row*ldpc_pkg::MAX_DEGREE + it.slt] =
						c >= ldpc_pkg::CODE_COLUMNS ? ldpc_pkg::CODE_COLUMNS-1 : c;
					deg_tab[it.row] = it.deg > ldpc_pkg::MAX_DEGREE
						? ldpc_pkg::MAX_DEGREE : it.deg;
				end
			end
			ldpc_pkg::CMD_LLR: begin
				if (c < ldpc_pkg::CODE_COLUMNS) post[c] = $signed(it.llr);
			end
			ldpc_pkg::CMD_RUN: begin
				decode_word();
				res.knd = 1'b1;
				res.llr = '0;
				res.col = '0;
				expected_results.push_back(res);
			end
			default: begin
				res.knd = 1'b0;
				res.llr = c < ldpc_pkg::CODE_COLUMNS ? 10'(post[c]) : '0;
				res.col = it.col;
				expected_results.push_back(res);
			end
		endcase
	endfunction

	function automatic void queue_item(ldpc_pkg::cmd_t op, int row, int slt, int col, int deg,
			int llr);
		dec_item_t it;
		it.op = op;
		it.row = 10'(row);
		it.slt = 3'(slt);
		it.col = 11'(col);
		it.deg = 4'(deg);
		it.llr = 10'(llr);
		if (op == ldpc_pkg::CMD_TABLE && row < ldpc_pkg::CHECK_ROWS)
			slot_written[row][slt] = 1'b1;
		if (op == ldpc_pkg::CMD_LLR && col < ldpc_pkg::CODE_COLUMNS && !col_written[col]) begin
			col_written[col] = 1'b1;
			written_cols.push_back(col);
		end
		pending_items.push_back(it);
	endfunction

	function automatic void queue_random_item(int run_pct);
		int p, row, slt, col, deg, pick;
		pick = $urandom_range(99);
		if (pick < run_pct) begin
			queue_item(ldpc_pkg::CMD_RUN, $urandom_range(1023), $urandom_range(7),
				$urandom_range(2047), $urandom_range(15), $urandom_range(1023));
		end else if (pick < 35) begin
			if ($urandom_range(9) == 0) begin
				row = $urandom_range(1023, ldpc_pkg::CHECK_ROWS);
			end else if ($urandom_range(4) == 0) begin
				row = $urandom_range(ldpc_pkg::CHECK_ROWS-1);
			end else begin
				row = $urandom_range(12);
				if (row == 12) row = ldpc_pkg::CHECK_ROWS - 1;
			end
			slt = $urandom_range(7);
			if (row < ldpc_pkg::CHECK_ROWS) begin
				p = 0;
				while (p < ldpc_pkg::MAX_DEGREE && (slot_written[row][p] || p == slt)) p++;
			end else begin
				p = 8;
			end
			deg = $urandom_range(p);
			if (p == ldpc_pkg::MAX_DEGREE && $urandom_range(3) == 0) deg = $urandom_range(15, 9);
			if (col_written[ldpc_pkg::CODE_COLUMNS-1] && $urandom_range(9) == 0)
				col = $urandom_range(2047, ldpc_pkg::CODE_COLUMNS);
			else
				col = written_cols[$urandom_range(written_cols.size()-1)];
			queue_item(ldpc_pkg::CMD_TABLE, row, slt, col, deg, $urandom_range(1023));
		end else if (pick < 65) begin
			if ($urandom_range(9) == 0) col = $urandom_range(2047, ldpc_pkg::CODE_COLUMNS);
			else if ($urandom_range(2) == 0) col = $urandom_range(ldpc_pkg::CODE_COLUMNS-1);
			else col = $urandom_range(40);
			queue_item(ldpc_pkg::CMD_LLR, $urandom_range(1023), $urandom_range(7), col,
				$urandom_range(15), $urandom_range(1023));
		end else begin
			if ($urandom_range(9) == 0) col = $urandom_range(2047, ldpc_pkg::CODE_COLUMNS);
			else col = written_cols[$urandom_range(written_cols.size()-1)];
			queue_item(ldpc_pkg::CMD_READ, $urandom_range(1023), $urandom_range(7), col,
				$urandom_range(15), $urandom_range(1023));
		end
	endfunction

	task automatic write_register(ldpc_pkg::cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= 2'(idx);
		cfg_data <= 6'(value);
		do @(posedge clk); while (!cfg_ready);
		if (idx == ldpc_pkg::CFG_OFFSET) pred_offset = value;
		else pred_iters = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	// Acceptance of input items and checking of results.
	always @(posedge clk) begin
		dec_result_t ex;
		taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken = 1'b1;
				predict_item(offered);
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result kind=%0d llr_out=%0d read_column=%0d",
						kind, llr_out, read_column);
					errors++;
				end else begin
					ex = expected_results.pop_front();
					if (kind !== ex.knd) begin
						$error("kind: expected %0d, actual %0d", ex.knd, kind);
						errors++;
					end
					if (llr_out !== ex.llr) begin
						$error("llr_out: expected %0d, actual %0d", ex.llr, llr_out);
						errors++;
					end
					if (read_column !== ex.col) begin
						$error("read_column: expected %0d, actual %0d", ex.col, read_column);
						errors++;
					end
				end
			end
		end
	end

	// Input driver.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || taken)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
				offered = pending_items.pop_front();
				in_valid <= 1'b1;
				cmd <= offered.op;
				check_row <= offered.row;
				slot <= offered.slt;
				column <= offered.col;
				row_degree <= offered.deg;
				llr_in <= offered.llr;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int offs[5];
		int iters[5];
		offs = '{0, 63, 17, 3, 40};
		iters = '{1, 2, 31, 7, 4};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings.
		queue_item(ldpc_pkg::CMD_LLR, 0, 0, 0, 0, -512);
		queue_item(ldpc_pkg::CMD_LLR, 0, 0, 1, 0, 511);
		queue_item(ldpc_pkg::CMD_LLR, 0, 0, 2, 0, 0);
		queue_item(ldpc_pkg::CMD_LLR, 0, 0, 1295, 0, -37);
		queue_item(ldpc_pkg::CMD_LLR, 1023, 7, 2047, 15, 100);
		queue_item(ldpc_pkg::CMD_READ, 0, 0, 0, 0, 0);
		queue_item(ldpc_pkg::CMD_READ, 0, 0, 2047, 0, 0);
		queue_item(ldpc_pkg::CMD_TABLE, 0, 0, 0, 1, 0);
		queue_item(ldpc_pkg::CMD_TABLE, 0, 1, 1, 2, 0);
		queue_item(ldpc_pkg::CMD_TABLE, 0, 2, 2047, 3, 0);
		queue_item(ldpc_pkg::CMD_TABLE, 647, 0, 1, 1, 0);
		queue_item(ldpc_pkg::CMD_TABLE, 1023, 7, 5, 4, 0);
		queue_item(ldpc_pkg::CMD_TABLE, 2, 0, 1295, 0, 0);
		for (int s = 0; s < ldpc_pkg::MAX_DEGREE; s++)
			queue_item(ldpc_pkg::CMD_TABLE, 1, s, s % 3, s == 7 ? 15 : s + 1, 0);
		queue_item(ldpc_pkg::CMD_RUN, 0, 0, 0, 0, 0);
		queue_item(ldpc_pkg::CMD_READ, 0, 0, 0, 0, 0);
		queue_item(ldpc_pkg::CMD_READ, 0, 0, 1, 0, 0);
		queue_item(ldpc_pkg::CMD_READ, 0, 0, 2, 0, 0);
		queue_item(ldpc_pkg::CMD_READ, 0, 0, 1295, 0, 0);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			write_register(ldpc_pkg::CFG_OFFSET, offs[ph]);
			write_register(ldpc_pkg::CFG_ITERATIONS, iters[ph]);
			in_idle_pct = ph == 3 ? 0 : 34;
			out_idle_pct = ph == 3 ? 0 : 34;
			if (ph == 1) hold_req++;
			for (int n = 0; n < 145; n++) queue_random_item(iters[ph] > 10 ? 1 : 3);
			wait_drained();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
